// ===== sv/fwvm_pkg.sv =====
// ----------------------------------------------------------------------------
// fwvm_pkg: shared types and constants of the wavetable voice mixer
// Sequencer states, action and register codes, fixed-point constants.
// ----------------------------------------------------------------------------
`default_nettype none

package fwvm_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_RAMP,
		ST_POS,
		ST_REDUCE,
		ST_WRITE,
		ST_RD0,
		ST_RD1,
		ST_RD2,
		ST_MUL,
		ST_POST,
		ST_OUT
	} state_t;

	// products taken in turn by the serial multiplier
	typedef enum logic [2:0] {
		PR_INTERP,
		PR_GAIN,
		PR_FB1,
		PR_FB2,
		PR_LEFT,
		PR_RIGHT
	} prod_t;

	localparam logic [1:0] ACT_LOAD = 2'd0;
	localparam logic [1:0] ACT_SET  = 2'd1;
	localparam logic [1:0] ACT_MIX  = 2'd2;

	localparam logic [2:0] CFG_RAMP_PERIOD = 3'd0;
	localparam logic [2:0] CFG_PITCH_STEP  = 3'd1;
	localparam logic [2:0] CFG_LVOL_STEP   = 3'd2;
	localparam logic [2:0] CFG_RVOL_STEP   = 3'd3;
	localparam logic [2:0] CFG_SAMPLE_END  = 3'd4;
	localparam logic [2:0] CFG_LOOP_SPAN   = 3'd5;
	localparam logic [2:0] CFG_INTERLEAVED = 3'd6;

	localparam logic [15:0] VR_POSITION = 16'd0;
	localparam logic [15:0] VR_PITCH    = 16'd1;
	localparam logic [15:0] VR_LVOL     = 16'd2;
	localparam logic [15:0] VR_RVOL     = 16'd3;
	localparam logic [15:0] VR_GAIN     = 16'd4;
	localparam logic [15:0] VR_FB1      = 16'd5;
	localparam logic [15:0] VR_FB2      = 16'd6;
	localparam logic [15:0] VR_STEP_K   = 16'd7;
	localparam logic [15:0] VR_STEP_B1  = 16'd8;
	localparam logic [15:0] VR_STEP_B2  = 16'd9;
	localparam logic [15:0] VR_HIST0    = 16'd10;
	localparam logic [15:0] VR_HIST1    = 16'd11;

	localparam int POS_INT_W  = 20;
	localparam int MUL_DIGITS = 8;
	localparam logic [4:0] RED_LAST = 5'(POS_INT_W - 1);
	localparam logic [2:0] DIG_LAST = 3'(MUL_DIGITS - 1);

	// half of 2^30, rounding bias for the 2.30 coefficient products
	localparam logic signed [37:0] ROUND_HALF = 38'sd536870912;

	localparam logic [15:0] SAT_MAX = 16'h7FFF;
	localparam logic [15:0] SAT_MIN = 16'h8000;

	function automatic logic [15:0] sat_add16(logic [15:0] d, logic [15:0] m);
		logic signed [16:0] s;
		s = $signed({d[15], d}) + $signed({m[15], m});
		if (s > $signed({1'b0, SAT_MAX}))
			return SAT_MAX;
		else if (s < $signed({1'b1, SAT_MIN}))
			return SAT_MIN;
		else
			return s[15:0];
	endfunction

endpackage

`default_nettype wire

// ===== sv/fwvm_ram.sv =====
// ----------------------------------------------------------------------------
// fwvm_ram: single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fwvm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 65536
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end

endmodule

`default_nettype wire

// ===== sv/filtered_wavetable_voice_mixer_unit.sv =====
// ----------------------------------------------------------------------------
// filtered_wavetable_voice_mixer_unit: one wavetable voice with filter and mix
// Interpolated wave read, two-pole filter, volume scaling, saturating mix.
// ----------------------------------------------------------------------------
// Usage:
//  Requests enter on in_valid/in_ready; action selects a wave sample load,
//  a voice register write or the mix of one frame. Only a mix request gives a
//  result, on out_valid/out_ready. Registers are written on cfg_valid/cfg_ready
//  (always ready); the user must write them only while the unit is idle, as
//  the unit itself does not enforce it. One request is in work at a time. A
//  wave load reduces its address modulo WAVE_DEPTH and a full frame its wave
//  index, one bit a cycle; a full frame then sends six products through one
//  32x4-bit multiplier one 4-bit digit a cycle. A register write and a
//  repeated frame do neither.
//  A finished result sits in the output register; the next request is taken
//  meanwhile, and a following frame waits at its end while out_ready is low.
//  Reset clears the voice state, sets the ramp countdown and ramp period to
//  one and empties the output register. Wave memory contents are undefined
//  until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module filtered_wavetable_voice_mixer_unit #(
	parameter int WAVE_DEPTH = 65536
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  action,
	input  wire logic [15:0] address,
	input  wire logic [31:0] value,
	input  wire logic        first_of_block,
	input  wire logic        repeat_frame,
	input  wire logic        left_enable,
	input  wire logic        right_enable,
	input  wire logic [15:0] dest_first,
	input  wire logic [15:0] dest_second,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      mixed_first,
	output logic [15:0]      mixed_second,
	output logic             voice_ended,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	localparam int AW = $clog2(WAVE_DEPTH);
	localparam int RW = AW + 1;
	localparam logic [RW-1:0] DEPTH_C = RW'(WAVE_DEPTH);

	fwvm_pkg::state_t state_q, state_d;
	fwvm_pkg::prod_t  prod_q;

	// configuration
	logic [15:0] ramp_period_q;
	logic [31:0] pitch_ramp_step_q, lvol_ramp_step_q, rvol_ramp_step_q;
	logic [27:0] sample_end_q, loop_span_q;
	logic        interleaved_q;

	// voice state
	logic [31:0] play_position_q, pitch_step_q, left_volume_q, right_volume_q;
	logic [39:0] pitch_acc_q, lvol_acc_q, rvol_acc_q;
	logic [31:0] gain_q, fb1_q, fb2_q, step_k_q, step_b1_q, step_b2_q;
	logic [31:0] hist0_q, hist1_q, held_left_q, held_right_q;
	logic [15:0] countdown_q;

	// request
	logic        is_write_q, len_q, ren_q, ended_q;
	logic [15:0] d1_q, d2_q, wdata_q;

	// index reduction
	localparam int POS_W_L = fwvm_pkg::POS_INT_W;
	logic [POS_W_L-1:0] red_src_q;
	logic [RW-1:0] red_r_q, red_shift, red_next, idx_inc;
	logic [4:0]    red_cnt_q;
	logic [AW-1:0] nidx, ram_addr;
	logic          ram_we;
	logic [15:0]   ram_rdata;

	// interpolation and multiplier
	logic [11:0]        fract_q;
	logic [15:0]        a_q;
	logic signed [31:0] mcand_q;
	logic [31:0]        mplier_q;
	logic signed [37:0] hi_q;
	logic [31:0]        lo_q;
	logic [2:0]         dig_q;
	logic [31:0]        ysum_q;
	logic signed [4:0]  dig_s;
	logic signed [36:0] mul_pp;
	logic signed [37:0] mul_t;
	logic [63:0]        prod_p;
	logic [33:0]        rnd_r;
	logic [31:0]        rnd_v, interp_x, vol_v, y_v;
	logic signed [31:0] ld_mcand;
	logic [31:0]        ld_mplier;
	logic signed [37:0] ld_bias;
	logic               out_load;

	logic        accept, at_end, dead_end;
	logic [15:0] cd_dec;
	logic [39:0] pitch_acc_n, lvol_acc_n, rvol_acc_n;
	logic [15:0] r1a, r1, r2;

	assign accept = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	assign at_end   = $signed(play_position_q) >= $signed({4'b0, sample_end_q});
	assign dead_end = at_end && (loop_span_q == 28'd0);
	assign cd_dec   = countdown_q - 16'd1;

	assign pitch_acc_n = pitch_acc_q + {{8{pitch_ramp_step_q[31]}}, pitch_ramp_step_q};
	assign lvol_acc_n  = lvol_acc_q + {{8{lvol_ramp_step_q[31]}}, lvol_ramp_step_q};
	assign rvol_acc_n  = rvol_acc_q + {{8{rvol_ramp_step_q[31]}}, rvol_ramp_step_q};

	// restoring reduction, most significant bit first
	assign red_shift = {red_r_q[AW-1:0], red_src_q[POS_W_L-1]};
	assign red_next  = (red_shift >= DEPTH_C) ? red_shift - DEPTH_C : red_shift;
	assign idx_inc   = red_r_q + RW'(1);
	assign nidx      = (idx_inc == DEPTH_C) ? '0 : idx_inc[AW-1:0];

	// radix-16 multiply, top digit signed
	assign dig_s  = {(dig_q == fwvm_pkg::DIG_LAST) & mplier_q[3], mplier_q[3:0]};
	assign mul_pp = mcand_q * dig_s;
	assign mul_t  = hi_q + {mul_pp[36], mul_pp};

	assign prod_p   = {hi_q[31:0], lo_q};
	assign interp_x = prod_p[43:12] + {{16{a_q[15]}}, a_q};
	assign rnd_r    = prod_p[63:30];
	assign rnd_v    = ((rnd_r[33] == rnd_r[32]) && (rnd_r[32] == rnd_r[31]))
		? rnd_r[31:0] : 32'hFFFF_FFFF;
	assign vol_v    = prod_p[44:13];
	assign y_v      = ysum_q - rnd_v;

	always_comb begin
		ld_mcand  = mcand_q;
		ld_mplier = '0;
		ld_bias   = '0;
		case (prod_q)
			fwvm_pkg::PR_INTERP: begin
				ld_mcand  = $signed(interp_x);
				ld_mplier = gain_q;
				ld_bias   = fwvm_pkg::ROUND_HALF - 38'(interp_x[31] ^ gain_q[31]);
			end
			fwvm_pkg::PR_GAIN: begin
				ld_mcand  = $signed(hist0_q);
				ld_mplier = fb1_q;
				ld_bias   = fwvm_pkg::ROUND_HALF - 38'(hist0_q[31] ^ fb1_q[31]);
			end
			fwvm_pkg::PR_FB1: begin
				ld_mcand  = $signed(hist1_q);
				ld_mplier = fb2_q;
				ld_bias   = fwvm_pkg::ROUND_HALF - 38'(hist1_q[31] ^ fb2_q[31]);
			end
			fwvm_pkg::PR_FB2: begin
				ld_mcand  = $signed(y_v);
				ld_mplier = left_volume_q;
			end
			fwvm_pkg::PR_LEFT: begin
				ld_mplier = right_volume_q;
			end
			default: begin
				ld_mplier = '0;
			end
		endcase
	end

	// final mix
	always_comb begin
		r1a = len_q ? fwvm_pkg::sat_add16(d1_q, held_left_q[15:0]) : d1_q;
		r1  = (ren_q && !interleaved_q) ? fwvm_pkg::sat_add16(r1a, held_right_q[15:0]) : r1a;
		r2  = (ren_q && interleaved_q) ? fwvm_pkg::sat_add16(d2_q, held_right_q[15:0]) : d2_q;
		if (ended_q) begin
			r1 = d1_q;
			r2 = d2_q;
		end
	end

	fwvm_ram #(
		.WIDTH(16),
		.DEPTH(WAVE_DEPTH)
	) u_wave (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(wdata_q),
		.rdata(ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			fwvm_pkg::ST_IDLE: begin
				if (in_valid) begin
					case (action)
						fwvm_pkg::ACT_LOAD: state_d = fwvm_pkg::ST_REDUCE;
						fwvm_pkg::ACT_MIX:
							state_d = repeat_frame ? fwvm_pkg::ST_OUT : fwvm_pkg::ST_CHECK;
						default: state_d = fwvm_pkg::ST_IDLE;
					endcase
				end
			end
			fwvm_pkg::ST_CHECK: begin
				if (dead_end)
					state_d = fwvm_pkg::ST_OUT;
				else if (cd_dec == 16'd0)
					state_d = fwvm_pkg::ST_RAMP;
				else
					state_d = fwvm_pkg::ST_POS;
			end
			fwvm_pkg::ST_RAMP: state_d = fwvm_pkg::ST_POS;
			fwvm_pkg::ST_POS:  state_d = fwvm_pkg::ST_REDUCE;
			fwvm_pkg::ST_REDUCE: begin
				if (red_cnt_q == fwvm_pkg::RED_LAST)
					state_d = is_write_q ? fwvm_pkg::ST_WRITE : fwvm_pkg::ST_RD0;
			end
			fwvm_pkg::ST_WRITE: state_d = fwvm_pkg::ST_IDLE;
			fwvm_pkg::ST_RD0:   state_d = fwvm_pkg::ST_RD1;
			fwvm_pkg::ST_RD1:   state_d = fwvm_pkg::ST_RD2;
			fwvm_pkg::ST_RD2:   state_d = fwvm_pkg::ST_MUL;
			fwvm_pkg::ST_MUL: begin
				if (dig_q == fwvm_pkg::DIG_LAST)
					state_d = fwvm_pkg::ST_POST;
			end
			fwvm_pkg::ST_POST: begin
				state_d = (prod_q == fwvm_pkg::PR_RIGHT) ? fwvm_pkg::ST_OUT : fwvm_pkg::ST_MUL;
			end
			fwvm_pkg::ST_OUT: begin
				if (!out_valid || out_ready)
					state_d = fwvm_pkg::ST_IDLE;
			end
			default: state_d = fwvm_pkg::ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_ready = 1'b0;
		ram_we   = 1'b0;
		ram_addr = red_r_q[AW-1:0];
		out_load = 1'b0;
		case (state_q)
			fwvm_pkg::ST_IDLE:  in_ready = 1'b1;
			fwvm_pkg::ST_WRITE: ram_we = 1'b1;
			fwvm_pkg::ST_RD1:   ram_addr = nidx;
			fwvm_pkg::ST_OUT:   out_load = !out_valid || out_ready;
			default: in_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fwvm_pkg::ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_period_q     <= 16'd1;
			pitch_ramp_step_q <= '0;
			lvol_ramp_step_q  <= '0;
			rvol_ramp_step_q  <= '0;
			sample_end_q      <= '0;
			loop_span_q       <= '0;
			interleaved_q     <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				fwvm_pkg::CFG_RAMP_PERIOD: ramp_period_q     <= cfg_data[15:0];
				fwvm_pkg::CFG_PITCH_STEP:  pitch_ramp_step_q <= cfg_data;
				fwvm_pkg::CFG_LVOL_STEP:   lvol_ramp_step_q  <= cfg_data;
				fwvm_pkg::CFG_RVOL_STEP:   rvol_ramp_step_q  <= cfg_data;
				fwvm_pkg::CFG_SAMPLE_END:  sample_end_q      <= cfg_data[27:0];
				fwvm_pkg::CFG_LOOP_SPAN:   loop_span_q       <= cfg_data[27:0];
				fwvm_pkg::CFG_INTERLEAVED: interleaved_q     <= cfg_data[0];
				default: interleaved_q <= interleaved_q;
			endcase
		end
	end

	// voice state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			play_position_q <= '0;
			pitch_step_q    <= '0;
			left_volume_q   <= '0;
			right_volume_q  <= '0;
			pitch_acc_q     <= '0;
			lvol_acc_q      <= '0;
			rvol_acc_q      <= '0;
			gain_q          <= '0;
			fb1_q           <= '0;
			fb2_q           <= '0;
			step_k_q        <= '0;
			step_b1_q       <= '0;
			step_b2_q       <= '0;
			hist0_q         <= '0;
			hist1_q         <= '0;
			held_left_q     <= '0;
			held_right_q    <= '0;
			countdown_q     <= 16'd1;
			ended_q         <= 1'b0;
		end else begin
			case (state_q)
				fwvm_pkg::ST_IDLE: begin
					if (accept && action == fwvm_pkg::ACT_SET) begin
						case (address)
							fwvm_pkg::VR_POSITION: play_position_q <= value;
							fwvm_pkg::VR_PITCH:    pitch_step_q    <= value;
							fwvm_pkg::VR_LVOL:     left_volume_q   <= value;
							fwvm_pkg::VR_RVOL:     right_volume_q  <= value;
							fwvm_pkg::VR_GAIN:     gain_q          <= value;
							fwvm_pkg::VR_FB1:      fb1_q           <= value;
							fwvm_pkg::VR_FB2:      fb2_q           <= value;
							fwvm_pkg::VR_STEP_K:   step_k_q        <= value;
							fwvm_pkg::VR_STEP_B1:  step_b1_q       <= value;
							fwvm_pkg::VR_STEP_B2:  step_b2_q       <= value;
							fwvm_pkg::VR_HIST0:    hist0_q         <= value;
							fwvm_pkg::VR_HIST1:    hist1_q         <= value;
							default: hist1_q <= hist1_q;
						endcase
					end
					if (accept && action == fwvm_pkg::ACT_MIX) begin
						ended_q <= repeat_frame && dead_end;
						if (!repeat_frame && first_of_block) begin
							countdown_q <= ramp_period_q;
							pitch_acc_q <= {pitch_step_q, 8'd0};
							lvol_acc_q  <= {left_volume_q, 8'd0};
							rvol_acc_q  <= {right_volume_q, 8'd0};
						end
					end
				end
				fwvm_pkg::ST_CHECK: begin
					if (dead_end) begin
						ended_q <= 1'b1;
					end else begin
						if (at_end)
							play_position_q <= play_position_q - {4'b0, loop_span_q};
						countdown_q <= (cd_dec == 16'd0) ? ramp_period_q : cd_dec;
					end
				end
				fwvm_pkg::ST_RAMP: begin
					pitch_acc_q    <= pitch_acc_n;
					pitch_step_q   <= pitch_acc_n[39:8];
					lvol_acc_q     <= lvol_acc_n;
					left_volume_q  <= lvol_acc_n[39:8];
					rvol_acc_q     <= rvol_acc_n;
					right_volume_q <= rvol_acc_n[39:8];
					gain_q         <= gain_q + step_k_q;
					fb1_q          <= fb1_q + step_b1_q;
					fb2_q          <= fb2_q + step_b2_q;
				end
				fwvm_pkg::ST_POS: begin
					play_position_q <= play_position_q + pitch_step_q;
				end
				fwvm_pkg::ST_POST: begin
					case (prod_q)
						fwvm_pkg::PR_FB2: begin
							hist1_q <= hist0_q;
							hist0_q <= y_v;
						end
						fwvm_pkg::PR_LEFT:  held_left_q  <= vol_v;
						fwvm_pkg::PR_RIGHT: held_right_q <= vol_v;
						default: held_right_q <= held_right_q;
					endcase
				end
				default: ended_q <= ended_q;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			fwvm_pkg::ST_IDLE: begin
				if (accept) begin
					is_write_q <= (action == fwvm_pkg::ACT_LOAD);
					wdata_q    <= value[15:0];
					red_src_q  <= POS_W_L'(address);
					red_r_q    <= '0;
					red_cnt_q  <= '0;
					len_q      <= left_enable;
					ren_q      <= right_enable;
					d1_q       <= dest_first;
					d2_q       <= dest_second;
				end
			end
			fwvm_pkg::ST_POS: begin
				red_src_q <= play_position_q[31:12];
				red_r_q   <= '0;
				red_cnt_q <= '0;
				fract_q   <= play_position_q[11:0];
			end
			fwvm_pkg::ST_REDUCE: begin
				red_r_q   <= red_next;
				red_src_q <= {red_src_q[POS_W_L-2:0], 1'b0};
				red_cnt_q <= red_cnt_q + 5'd1;
			end
			fwvm_pkg::ST_RD1: begin
				a_q <= ram_rdata;
			end
			fwvm_pkg::ST_RD2: begin
				mcand_q  <= {{16{ram_rdata[15]}}, ram_rdata} - {{16{a_q[15]}}, a_q};
				mplier_q <= {20'd0, fract_q};
				hi_q     <= '0;
				dig_q    <= '0;
				prod_q   <= fwvm_pkg::PR_INTERP;
			end
			fwvm_pkg::ST_MUL: begin
				hi_q     <= mul_t >>> 4;
				lo_q     <= {mul_t[3:0], lo_q[31:4]};
				mplier_q <= {4'd0, mplier_q[31:4]};
				dig_q    <= dig_q + 3'd1;
			end
			fwvm_pkg::ST_POST: begin
				case (prod_q)
					fwvm_pkg::PR_GAIN: ysum_q <= rnd_v;
					fwvm_pkg::PR_FB1:  ysum_q <= ysum_q + rnd_v;
					default: ysum_q <= ysum_q;
				endcase
				mcand_q  <= ld_mcand;
				mplier_q <= ld_mplier;
				hi_q     <= ld_bias;
				dig_q    <= '0;
				prod_q   <= fwvm_pkg::prod_t'(prod_q + 3'd1);
			end
			fwvm_pkg::ST_OUT: begin
				if (out_load) begin
					mixed_first  <= r1;
					mixed_second <= r2;
					voice_ended  <= ended_q;
				end
			end
			default: dig_q <= dig_q;
		endcase
	end

endmodule

`default_nettype wire

// ===== bench/fwvm_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fwvm_result_checker: expected-mix predictor and comparator
// Follows every accepted request and register write of the voice mixer,
// computes the frame each mix request should produce and compares each
// delivered result, field by field, with the oldest one still awaited.
// ----------------------------------------------------------------------------

module fwvm_result_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  action,
	input  logic [15:0] address,
	input  logic [31:0] value,
	input  logic        first_of_block,
	input  logic        repeat_frame,
	input  logic        left_enable,
	input  logic        right_enable,
	input  logic [15:0] dest_first,
	input  logic [15:0] dest_second,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [15:0] mixed_first,
	input  logic [15:0] mixed_second,
	input  logic        voice_ended,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          errors,
	output int          pending,
	output int          frames_seen,
	output int          ended_seen
);

	typedef struct packed {
		logic [15:0] first;
		logic [15:0] second;
		logic        ended;
	} mix_result_t;

	mix_result_t awaited_mix[$];

	logic [15:0] wave_mem [0:65535];

	// voice state
	logic [31:0] position, pitch, left_vol, right_vol;
	logic [39:0] pitch_acc, left_acc, right_acc;
	logic [31:0] gain, fb1, fb2;
	logic [31:0] coef_step [0:2];
	logic [31:0] hist [0:1];
	logic [15:0] countdown;
	logic [31:0] held_mix [0:1];

	// configuration
	logic [15:0] ramp_period;
	logic [31:0] pitch_ramp, left_ramp, right_ramp;
	logic [27:0] sample_end, loop_span;
	logic        interleaved;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		errors++;
		$display("%0t mismatch: %s got %h expected %h", $realtime, what, got, want);
	endtask

	function automatic int rdiv30(input int a, input int b);
		longint p;
		longint unsigned mag, q;
		p = longint'(a) * longint'(b);
		mag = (p < 0) ? -p : p;
		q = (mag + 64'd536870912) >> 30;
		if (p < 0)
			return (q > 64'h80000000) ? -1 : int'(-longint'(q));
		return (q > 64'h7FFFFFFF) ? -1 : int'(q);
	endfunction

	function automatic logic [15:0] sat_mix(input logic [15:0] d, input logic [15:0] m);
		int s;
		s = int'($signed(d)) + int'($signed(m));
		if (s > 32767)
			return 16'h7FFF;
		if (s < -32768)
			return 16'h8000;
		return s[15:0];
	endfunction

	function automatic logic [39:0] acc_step(input logic [39:0] acc, input logic [31:0] st);
		return acc + {{8{st[31]}}, st};
	endfunction

	function automatic logic at_stop();
		return $signed(position) >= $signed({4'h0, sample_end}) && loop_span == 0;
	endfunction

	task automatic run_mix();
		mix_result_t r;
		logic [15:0] idx, nidx;
		int a, b, x, y, fr;
		longint t, sum;
		r.first = dest_first;
		r.second = dest_second;
		r.ended = 1'b0;
		if (repeat_frame) begin
			if (at_stop()) begin
				r.ended = 1'b1;
				awaited_mix.push_back(r);
				return;
			end
		end else begin
			if (first_of_block) begin
				countdown = ramp_period;
				pitch_acc = {pitch, 8'h00};
				left_acc = {left_vol, 8'h00};
				right_acc = {right_vol, 8'h00};
			end
			if ($signed(position) >= $signed({4'h0, sample_end})) begin
				if (loop_span != 0) begin
					position = position - {4'h0, loop_span};
				end else begin
					r.ended = 1'b1;
					awaited_mix.push_back(r);
					return;
				end
			end
			countdown = countdown - 16'd1;
			if (countdown == 0) begin
				countdown = ramp_period;
				pitch_acc = acc_step(pitch_acc, pitch_ramp);
				pitch = pitch_acc[39:8];
				left_acc = acc_step(left_acc, left_ramp);
				left_vol = left_acc[39:8];
				right_acc = acc_step(right_acc, right_ramp);
				right_vol = right_acc[39:8];
				gain = gain + coef_step[0];
				fb1 = fb1 + coef_step[1];
				fb2 = fb2 + coef_step[2];
			end
			idx = position[27:12];
			nidx = idx + 16'd1;
			fr = int'({20'h0, position[11:0]});
			position = position + pitch;
			a = int'($signed(wave_mem[idx]));
			b = int'($signed(wave_mem[nidx]));
			t = longint'(b - a) * longint'(fr);
			x = int'(t >>> 12) + a;
			sum = longint'(rdiv30(x, $signed(gain)))
				+ longint'(rdiv30($signed(hist[0]), $signed(fb1)))
				- longint'(rdiv30($signed(hist[1]), $signed(fb2)));
			y = int'(sum[31:0]);
			hist[1] = hist[0];
			hist[0] = y;
			t = (longint'(y) * longint'($signed(left_vol))) >>> 13;
			held_mix[0] = t[31:0];
			t = (longint'(y) * longint'($signed(right_vol))) >>> 13;
			held_mix[1] = t[31:0];
		end
		if (left_enable)
			r.first = sat_mix(r.first, held_mix[0][15:0]);
		if (right_enable) begin
			if (interleaved)
				r.second = sat_mix(r.second, held_mix[1][15:0]);
			else
				r.first = sat_mix(r.first, held_mix[1][15:0]);
		end
		awaited_mix.push_back(r);
	endtask

	task automatic apply_request();
		case (action)
			fwvm_pkg::ACT_LOAD: wave_mem[address] = value[15:0];
			fwvm_pkg::ACT_SET: begin
				case (address)
					fwvm_pkg::VR_POSITION: position = value;
					fwvm_pkg::VR_PITCH:    pitch = value;
					fwvm_pkg::VR_LVOL:     left_vol = value;
					fwvm_pkg::VR_RVOL:     right_vol = value;
					fwvm_pkg::VR_GAIN:     gain = value;
					fwvm_pkg::VR_FB1:      fb1 = value;
					fwvm_pkg::VR_FB2:      fb2 = value;
					fwvm_pkg::VR_STEP_K:   coef_step[0] = value;
					fwvm_pkg::VR_STEP_B1:  coef_step[1] = value;
					fwvm_pkg::VR_STEP_B2:  coef_step[2] = value;
					fwvm_pkg::VR_HIST0:    hist[0] = value;
					fwvm_pkg::VR_HIST1:    hist[1] = value;
					default: ;
				endcase
			end
			fwvm_pkg::ACT_MIX: run_mix();
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position = 0; pitch = 0; left_vol = 0; right_vol = 0;
			pitch_acc = '0; left_acc = '0; right_acc = '0;
			gain = 0; fb1 = 0; fb2 = 0;
			coef_step[0] = 0; coef_step[1] = 0; coef_step[2] = 0;
			hist[0] = 0; hist[1] = 0;
			held_mix[0] = 0; held_mix[1] = 0;
			countdown = 16'd1;
			ramp_period = 16'd1;
			pitch_ramp = 0; left_ramp = 0; right_ramp = 0;
			sample_end = '0; loop_span = '0; interleaved = 1'b0;
			awaited_mix.delete();
			errors = 0;
			pending = 0;
			frames_seen = 0;
			ended_seen = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (awaited_mix.size() == 0) begin
					report("result with no request pending", {mixed_first, mixed_second}, 0);
				end else begin
					mix_result_t w;
					w = awaited_mix.pop_front();
					frames_seen++;
					if (w.ended)
						ended_seen++;
					if (mixed_first !== w.first)
						report("mixed_first", 32'(mixed_first), 32'(w.first));
					if (mixed_second !== w.second)
						report("mixed_second", 32'(mixed_second), 32'(w.second));
					if (voice_ended !== w.ended)
						report("voice_ended", 32'(voice_ended), 32'(w.ended));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					fwvm_pkg::CFG_RAMP_PERIOD: ramp_period = cfg_data[15:0];
					fwvm_pkg::CFG_PITCH_STEP:  pitch_ramp = cfg_data;
					fwvm_pkg::CFG_LVOL_STEP:   left_ramp = cfg_data;
					fwvm_pkg::CFG_RVOL_STEP:   right_ramp = cfg_data;
					fwvm_pkg::CFG_SAMPLE_END:  sample_end = cfg_data[27:0];
					fwvm_pkg::CFG_LOOP_SPAN:   loop_span = cfg_data[27:0];
					fwvm_pkg::CFG_INTERLEAVED: interleaved = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				apply_request();
			pending = awaited_mix.size();
		end
	end

endmodule

// ===== bench/tb_filtered_wavetable_voice_mixer_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_filtered_wavetable_voice_mixer_unit: voice mixer testbench top
// Loads a wave window at both ends of memory, runs a short directed pass and
// then random phases with varied loop, ramp and mix settings, random idling
// on both channels and a long output hold-off. Checking is in the checker.
// ----------------------------------------------------------------------------

module tb_filtered_wavetable_voice_mixer_unit;

	localparam logic [1:0] ACT_NONE = 2'd3;
	localparam int ENTRY = 4096;
	localparam int WINDOW = 128;

	typedef enum int {PH_LOOP, PH_STOP, PH_ZERO_END, PH_FAR_END} phase_kind_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid, in_ready;
	logic [1:0]  action;
	logic [15:0] address;
	logic [31:0] value;
	logic        first_of_block, repeat_frame, left_enable, right_enable;
	logic [15:0] dest_first, dest_second;
	logic        out_valid, out_ready;
	logic [15:0] mixed_first, mixed_second;
	logic        voice_ended;
	logic        cfg_valid, cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	int          errors, pending, frames_seen, ended_seen;

	// receiver control
	logic calm;
	logic hold_request;
	int   hold_left;

	// per-phase limits that keep reads inside the loaded wave window
	int pos_min, pos_max, pitch_min, pitch_max;
	int phases_run;

	filtered_wavetable_voice_mixer_unit uut (.*);
	fwvm_result_checker chk (.*);

	always #2 clk = ~clk;

	initial begin
		#4_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		out_ready = 1'b0;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left = 400;
				out_ready <= 1'b0;
			end else begin
				out_ready <= calm || ($urandom_range(99) >= 38);
			end
		end
	end

	function automatic int rand_between(input int lo, input int hi);
		return lo + int'($urandom_range(hi - lo));
	endfunction

	function automatic logic [15:0] rand_sample();
		case ($urandom_range(7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(7))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			default: return $urandom();
		endcase
	endfunction

	task automatic send(input logic [1:0] act, input logic [15:0] addr, input logic [31:0] val,
			input logic fb, input logic rep, input logic len, input logic ren,
			input logic [15:0] d1, input logic [15:0] d2);
		if (!calm) begin
			while ($urandom_range(99) < 38) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		action <= act;
		address <= addr;
		value <= val;
		first_of_block <= fb;
		repeat_frame <= rep;
		left_enable <= len;
		right_enable <= ren;
		dest_first <= d1;
		dest_second <= d2;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic load_wave(input logic [15:0] addr, input logic [31:0] val);
		send(fwvm_pkg::ACT_LOAD, addr, val, 1'($urandom()), 1'($urandom()), 1'($urandom()),
			1'($urandom()), 16'($urandom()), 16'($urandom()));
	endtask

	task automatic set_voice(input logic [15:0] idx, input logic [31:0] val);
		send(fwvm_pkg::ACT_SET, idx, val, 1'($urandom()), 1'($urandom()), 1'($urandom()),
			1'($urandom()), 16'($urandom()), 16'($urandom()));
	endtask

	task automatic mix(input logic fb, input logic rep, input logic len, input logic ren,
			input logic [15:0] d1, input logic [15:0] d2);
		send(fwvm_pkg::ACT_MIX, 16'($urandom()), $urandom(), fb, rep, len, ren, d1, d2);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// sender pause: stop offering until every mix has come back and the unit is quiet
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	function automatic logic [31:0] voice_value(input logic [15:0] idx);
		if (idx == fwvm_pkg::VR_POSITION)
			return rand_between(pos_min, pos_max);
		if (idx == fwvm_pkg::VR_PITCH)
			return rand_between(pitch_min, pitch_max);
		return rand_word();
	endfunction

	task automatic run_phase(input phase_kind_t kind, input int n_items);
		int period, end_v, span, r;
		logic ramping;
		case ($urandom_range(5))
			0: period = 1;
			1: period = 65535;
			2: period = 0;
			3: period = rand_between(2, 8);
			4: period = rand_between(200, 65535);
			default: period = rand_between(1, 16);
		endcase
		// no pitch ramp can fire within a phase unless the period is short
		ramping = period > 0 && period < 128;
		pos_min = -16 * ENTRY;
		pitch_min = -(ENTRY / 2);
		case (kind)
			PH_LOOP: begin
				end_v = rand_between(16 * ENTRY, 100 * ENTRY);
				span = rand_between(8 * ENTRY, end_v + 16 * ENTRY);
				pos_max = end_v + 4 * ENTRY;
				pitch_max = 4 * ENTRY;
			end
			PH_STOP: begin
				end_v = rand_between(0, 64 * ENTRY);
				span = 0;
				pos_max = 16 * ENTRY;
				pitch_max = ENTRY / 8;
			end
			PH_ZERO_END: begin
				end_v = 0;
				span = rand_between(1, 32 * ENTRY);
				pos_max = 4 * ENTRY;
				pitch_max = ENTRY;
			end
			default: begin
				end_v = 32'h0FFFFFFF;
				span = ($urandom_range(1) == 0) ? 32'h0FFFFFFF : $urandom();
				pos_max = 16 * ENTRY;
				pitch_max = ENTRY / 8;
			end
		endcase
		drain();
		write_reg(fwvm_pkg::CFG_RAMP_PERIOD, {16'($urandom()), 16'(period)});
		write_reg(fwvm_pkg::CFG_PITCH_STEP,
			ramping ? rand_between(-4096, 4096) : rand_word());
		write_reg(fwvm_pkg::CFG_LVOL_STEP, rand_word());
		write_reg(fwvm_pkg::CFG_RVOL_STEP, rand_word());
		write_reg(fwvm_pkg::CFG_SAMPLE_END, {4'($urandom_range(15)), 28'(end_v)});
		write_reg(fwvm_pkg::CFG_LOOP_SPAN, {4'($urandom_range(15)), 28'(span)});
		write_reg(fwvm_pkg::CFG_INTERLEAVED, $urandom());
		for (int i = 0; i <= 11; i++)
			set_voice(16'(i), voice_value(16'(i)));
		// the first frame reloads the ramp countdown and accumulators
		mix(1'b1, 1'b0, 1'($urandom()), 1'($urandom()), rand_sample(), rand_sample());
		for (int i = 1; i < n_items; i++) begin
			r = $urandom_range(99);
			if (r < 58) begin
				mix($urandom_range(9) == 0, $urandom_range(4) == 0, 1'($urandom()),
					1'($urandom()), rand_sample(), rand_sample());
			end else if (r < 75) begin
				logic [15:0] idx;
				idx = ($urandom_range(9) == 0) ? 16'($urandom()) : 16'($urandom_range(11));
				set_voice(idx, voice_value(idx));
			end else if (r < 95) begin
				load_wave(16'($urandom()), $urandom());
			end else begin
				send(ACT_NONE, 16'($urandom()), $urandom(), 1'($urandom()), 1'($urandom()),
					1'($urandom()), 1'($urandom()), 16'($urandom()), 16'($urandom()));
			end
		end
		phases_run++;
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = fwvm_pkg::ACT_LOAD;
		address = '0;
		value = '0;
		first_of_block = 1'b0;
		repeat_frame = 1'b0;
		left_enable = 1'b0;
		right_enable = 1'b0;
		dest_first = '0;
		dest_second = '0;
		cfg_valid = 1'b0;
		cfg_index = fwvm_pkg::CFG_RAMP_PERIOD;
		cfg_data = '0;
		calm = 1'b0;
		hold_request = 1'b0;
		phases_run = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// wave window at both ends of memory, extremes at the bottom
		for (int i = 0; i < WINDOW; i++)
			load_wave(16'(i), (i == 0) ? 32'h00007FFF : (i == 1) ? 32'hFFFF8000 : $urandom());
		for (int i = 65536 - WINDOW; i < 65536; i++)
			load_wave(16'(i), $urandom());

		// reset settings: position already at the end with no loop
		mix(1'b1, 1'b0, 1'b1, 1'b1, 16'h1234, 16'h8000);
		mix(1'b0, 1'b1, 1'b1, 1'b0, 16'h7FFF, 16'h0001);
		drain();
		write_reg(fwvm_pkg::CFG_SAMPLE_END, 64 * ENTRY);
		write_reg(fwvm_pkg::CFG_LOOP_SPAN, 32 * ENTRY);
		write_reg(fwvm_pkg::CFG_INTERLEAVED, 32'd1);
		set_voice(fwvm_pkg::VR_POSITION, 32'h00000800);
		set_voice(fwvm_pkg::VR_PITCH, 32'h00001800);
		set_voice(fwvm_pkg::VR_LVOL, 32'h7FFFFFFF);
		set_voice(fwvm_pkg::VR_RVOL, 32'h80000000);
		set_voice(fwvm_pkg::VR_GAIN, 32'h40000000);
		set_voice(fwvm_pkg::VR_FB1, 32'h7FFFFFFF);
		set_voice(fwvm_pkg::VR_FB2, 32'h80000000);
		set_voice(fwvm_pkg::VR_HIST0, 32'h7FFFFFFF);
		set_voice(fwvm_pkg::VR_HIST1, 32'h80000000);
		set_voice(16'd12, 32'hFFFFFFFF);
		send(ACT_NONE, 16'hFFFF, 32'hFFFFFFFF, 1'b1, 1'b1, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF);
		mix(1'b1, 1'b0, 1'b1, 1'b1, 16'h7FFF, 16'h8000);
		mix(1'b0, 1'b1, 1'b1, 1'b0, 16'h8000, 16'h0000);
		mix(1'b0, 1'b0, 1'b0, 1'b1, 16'h0000, 16'h7FFF);
		mix(1'b0, 1'b0, 1'b0, 1'b0, 16'h5555, 16'hAAAA);
		mix(1'b0, 1'b0, 1'b1, 1'b1, 16'h0000, 16'h0000);
		mix(1'b0, 1'b1, 1'b1, 1'b1, 16'h0000, 16'h0000);
		drain();
		write_reg(fwvm_pkg::CFG_INTERLEAVED, 32'd0);
		mix(1'b0, 1'b0, 1'b1, 1'b1, 16'h0000, 16'h0000);
		mix(1'b0, 1'b1, 1'b1, 1'b1, 16'h7FFF, 16'h8000);

		for (int p = 0; p < 15; p++) begin
			calm = (p == 5 || p == 6);
			if (p == 3)
				hold_request = 1'b1;
			run_phase(phase_kind_t'(p % 4), rand_between(60, 100));
		end
		calm = 1'b0;

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		$display("covered %0d random phases of loop, stop, zero-end and far-end settings",
			phases_run);
		$display("checked %0d mixed frames, %0d of them reporting the voice ended",
			frames_seen, ended_seen);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/fwvm_pkg.sv
sv/fwvm_ram.sv
sv/filtered_wavetable_voice_mixer_unit.sv
bench/fwvm_result_checker.sv
bench/tb_filtered_wavetable_voice_mixer_unit.sv
